// ===== rtl/dcsp_pkg.sv =====
// shared types and constants for the display command sequence player
package dcsp_pkg;

  localparam int SEQ_W    = 8;
  localparam int MS_W     = 9;
  localparam int KIND_W   = 2;
  localparam int BLEFT_W  = 15;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [KIND_W-1:0] KIND_CMD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PAUSE = 2'd2;

  localparam logic [SEQ_W-1:0] DELAY_FLAG      = 8'h80;
  localparam logic [SEQ_W-1:0] DELAY_LONG_CODE = 8'd255;
  localparam logic [MS_W-1:0]  DELAY_LONG_MS   = 9'd500;

  // one queue entry: a first result and an optional trailing zero-length pause
  typedef struct packed {
    logic [KIND_W-1:0] a_kind;
    logic [SEQ_W-1:0]  a_byte;
    logic [MS_W-1:0]   a_ms;
    logic              a_wait;
    logic              b_valid;
    logic              b_wait;
  } dcsp_entry_t;

endpackage

// ===== rtl/dcsp_front.sv =====
// front end: parses sequence bytes and classifies them into queue entries
module dcsp_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_bit,
  input  logic                  in_take,
  input  logic [dcsp_pkg::SEQ_W-1:0] in_byte,
  input  logic                  in_last,
  input  logic                  in_wait,
  output logic                  push,
  output dcsp_pkg::dcsp_entry_t push_entry
);
  import dcsp_pkg::*;

  localparam logic [2:0] PH_CMD    = 3'd0;
  localparam logic [2:0] PH_LEN    = 3'd1;
  localparam logic [2:0] PH_LEN_LO = 3'd2;
  localparam logic [2:0] PH_DATA   = 3'd3;
  localparam logic [2:0] PH_DELAY  = 3'd4;

  logic [2:0]         phase_r, phase_nxt;
  logic [BLEFT_W-1:0] bleft_r, bleft_nxt;
  logic               dly_r, dly_nxt;
  logic               two_byte_r;
  logic [BLEFT_W-1:0] bleft_dec;

  assign bleft_dec = bleft_r - BLEFT_W'(1);

  always_comb begin
    phase_nxt  = phase_r;
    bleft_nxt  = bleft_r;
    dly_nxt    = dly_r;
    push       = 1'b0;
    push_entry = '0;
    case (phase_r)
      PH_LEN, PH_LEN_LO: begin
        if (phase_r == PH_LEN) begin
          dly_nxt = in_byte[7];
          if (two_byte_r) begin
            bleft_nxt = {in_byte[6:0], 8'h00};
          end else begin
            bleft_nxt = {8'h00, in_byte[6:0]};
          end
        end else begin
          bleft_nxt = bleft_r | {7'h00, in_byte};
        end
        if (phase_r == PH_LEN && two_byte_r) begin
          phase_nxt = PH_LEN_LO;
        end else if (bleft_nxt != '0) begin
          phase_nxt = PH_DATA;
        end else if (dly_nxt) begin
          phase_nxt = PH_DELAY;
        end else begin
          // empty entry, no delay: it ends right here
          push              = 1'b1;
          push_entry.a_kind = KIND_PAUSE;
          push_entry.a_wait = in_wait;
          phase_nxt         = PH_CMD;
        end
      end
      PH_DATA: begin
        push              = 1'b1;
        push_entry.a_kind = KIND_DATA;
        push_entry.a_byte = in_byte;
        bleft_nxt         = bleft_dec;
        if (bleft_dec == '0) begin
          if (dly_r) begin
            phase_nxt = PH_DELAY;
          end else begin
            push_entry.b_valid = 1'b1;
            push_entry.b_wait  = in_wait;
            phase_nxt          = PH_CMD;
          end
        end
      end
      PH_DELAY: begin
        push              = 1'b1;
        push_entry.a_kind = KIND_PAUSE;
        push_entry.a_ms   = (in_byte == DELAY_LONG_CODE) ? DELAY_LONG_MS : {1'b0, in_byte};
        push_entry.a_wait = in_wait;
        dly_nxt           = 1'b0;
        phase_nxt         = PH_CMD;
      end
      default: begin
        push              = 1'b1;
        push_entry.a_kind = KIND_CMD;
        push_entry.a_byte = in_byte;
        bleft_nxt         = '0;
        dly_nxt           = 1'b0;
        phase_nxt         = PH_LEN;
      end
    endcase
    if (in_last) begin
      phase_nxt = PH_CMD;
      bleft_nxt = '0;
      dly_nxt   = 1'b0;
    end
    push = push & in_take;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_CMD;
      bleft_r    <= '0;
      dly_r      <= 1'b0;
      two_byte_r <= 1'b0;
    end else begin
      if (in_take) begin
        phase_r <= phase_nxt;
        bleft_r <= bleft_nxt;
        dly_r   <= dly_nxt;
      end
      if (cfg_we) begin
        two_byte_r <= cfg_bit;
      end
    end
  end

endmodule

// ===== rtl/dcsp_queue.sv =====
// short queue of parsed entries between front and back
module dcsp_queue #(
  parameter int DEPTH = dcsp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  dcsp_pkg::dcsp_entry_t push_entry,
  input  logic                  pop,
  output logic                  full,
  output logic                  not_empty,
  output dcsp_pkg::dcsp_entry_t head
);
  import dcsp_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  dcsp_entry_t   slot_r [DEPTH];
  logic [AW-1:0] wptr_r, wptr_nxt;
  logic [AW-1:0] rptr_r, rptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_pop;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rptr_r];
  assign do_pop    = pop & not_empty;

  always_comb begin
    wptr_nxt  = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + AW'(1);
    rptr_nxt  = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + AW'(1);
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (!push && do_pop) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= wptr_nxt;
      end
      if (do_pop) begin
        rptr_r <= rptr_nxt;
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== rtl/dcsp_back.sv =====
// back end: expands queue entries into result items behind an output register
module dcsp_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid,
  input  dcsp_pkg::dcsp_entry_t q_head,
  output logic                  q_pop,
  output logic                  res_valid,
  input  logic                  res_ready,
  output logic [dcsp_pkg::KIND_W-1:0] res_kind,
  output logic [dcsp_pkg::SEQ_W-1:0]  res_byte,
  output logic [dcsp_pkg::MS_W-1:0]   res_ms,
  output logic                  res_wait,
  output logic                  res_last
);
  import dcsp_pkg::*;

  logic              valid_r, valid_nxt;
  logic              pend_r, pend_nxt;
  logic              pend_wait_r, pend_wait_nxt;
  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [SEQ_W-1:0]  byte_r, byte_nxt;
  logic [MS_W-1:0]   ms_r, ms_nxt;
  logic              wait_r, wait_nxt;
  logic              last_r, last_nxt;
  logic              load;

  assign load = !valid_r || res_ready;

  always_comb begin
    valid_nxt     = valid_r;
    pend_nxt      = pend_r;
    pend_wait_nxt = pend_wait_r;
    kind_nxt      = kind_r;
    byte_nxt      = byte_r;
    ms_nxt        = ms_r;
    wait_nxt      = wait_r;
    last_nxt      = last_r;
    q_pop         = 1'b0;
    if (load) begin
      if (pend_r) begin
        // trailing zero-length pause of the previous entry
        valid_nxt = 1'b1;
        kind_nxt  = KIND_PAUSE;
        byte_nxt  = '0;
        ms_nxt    = '0;
        wait_nxt  = pend_wait_r;
        last_nxt  = 1'b1;
        pend_nxt  = 1'b0;
      end else if (q_valid) begin
        q_pop         = 1'b1;
        valid_nxt     = 1'b1;
        kind_nxt      = q_head.a_kind;
        byte_nxt      = q_head.a_byte;
        ms_nxt        = q_head.a_ms;
        wait_nxt      = q_head.a_wait;
        last_nxt      = !q_head.b_valid;
        pend_nxt      = q_head.b_valid;
        pend_wait_nxt = q_head.b_wait;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      pend_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_wait_r <= pend_wait_nxt;
    kind_r      <= kind_nxt;
    byte_r      <= byte_nxt;
    ms_r        <= ms_nxt;
    wait_r      <= wait_nxt;
    last_r      <= last_nxt;
  end

  assign res_valid = valid_r;
  assign res_kind  = kind_r;
  assign res_byte  = byte_r;
  assign res_ms    = ms_r;
  assign res_wait  = wait_r;
  assign res_last  = last_r;

endmodule

// ===== rtl/display_command_sequence_player_top.sv =====
// top level of the display command sequence player
// an item's first result is registered in the entry queue and then in the output register
// throughput: one item per cycle while the entry queue has room; a last data byte with no
//   delay gives two results, and the entry queue absorbs the extra one
// reset: rst_n synchronous active low; parser back to expecting a command,
//   queue emptied, no result pending, two_byte_length cleared
module display_command_sequence_player_top #(
  parameter int QUEUE_DEPTH = dcsp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // sequence input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // seq_byte[7:0], wait_busy[8], zero pad
  input  logic        in_tlast,   // seq_last
  // result output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // byte_out[7:0], pause_ms[16:8], wait_after[17], zero pad
  output logic [1:0]  out_tuser,  // kind
  output logic        out_tlast,  // run_last
  // configuration write: two_byte_length
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);
  import dcsp_pkg::*;

  logic              in_take;
  logic              push;
  dcsp_entry_t       push_entry;
  logic              q_full;
  logic              q_not_empty;
  dcsp_entry_t       q_head;
  logic              q_pop;
  logic [KIND_W-1:0] res_kind;
  logic [SEQ_W-1:0]  res_byte;
  logic [MS_W-1:0]   res_ms;
  logic              res_wait;

  // config register always ready; user must land writes while idle, unenforced by block
  assign cfg_ready = 1'b1;

  // the front only stalls when the queue has no room for an entry
  assign in_tready = !q_full;
  assign in_take   = in_tvalid && in_tready;

  // front: parser state and classification of each byte
  dcsp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid),
    .cfg_bit    (cfg_data),
    .in_take    (in_take),
    .in_byte    (in_tdata[7:0]),
    .in_last    (in_tlast),
    .in_wait    (in_tdata[8]),
    .push       (push),
    .push_entry (push_entry)
  );

  // decoupling queue
  dcsp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .head       (q_head)
  );

  // back: result expansion and output register
  dcsp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_not_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res_kind  (res_kind),
    .res_byte  (res_byte),
    .res_ms    (res_ms),
    .res_wait  (res_wait),
    .res_last  (out_tlast)
  );

  assign out_tdata = {6'd0, res_wait, res_ms, res_byte};
  assign out_tuser = res_kind;

endmodule

// ===== tb/sv/dcsp_seq_checker.sv =====
// result checker for the display command sequence player: predicts and compares results
`timescale 1ns / 100ps
module dcsp_seq_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [15:0] in_tdata,   // seq_byte[7:0], wait_busy[8], zero pad
  input  logic        in_tlast,   // seq_last
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // byte_out[7:0], pause_ms[16:8], wait_after[17], zero pad
  input  logic [1:0]  out_tuser,  // kind
  input  logic        out_tlast,  // run_last
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_data,
  output int          errors,
  output int          pending,
  output int          checked
);
  import dcsp_pkg::*;

  typedef enum logic [2:0] {
    PH_CMD, PH_LEN, PH_LEN_LO, PH_DATA, PH_DELAY
  } parse_phase_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  byte_out;
    logic [MS_W-1:0]   pause_ms;
    logic              wait_after;
    logic              run_last;
  } seq_result_t;

  seq_result_t        awaited_q[$];
  parse_phase_t       parse_ph;
  logic [BLEFT_W-1:0] bytes_left;
  logic               delay_req;
  logic               long_len;

  function automatic seq_result_t make_result(logic [KIND_W-1:0] k, logic [SEQ_W-1:0] b,
                                              logic [MS_W-1:0] ms, logic w);
    seq_result_t r;
    r.kind       = k;
    r.byte_out   = b;
    r.pause_ms   = ms;
    r.wait_after = w;
    r.run_last   = 1'b0;
    return r;
  endfunction

  // advance the parser by one sequence byte and queue what it should emit
  task automatic play_byte(input logic [SEQ_W-1:0] b, input logic last, input logic wb);
    seq_result_t res[2];
    int          n;
    logic        len_done;
    n        = 0;
    len_done = 1'b0;
    case (parse_ph)
      PH_LEN: begin
        delay_req = b[7];
        if (long_len) begin
          bytes_left = {b[6:0], 8'h00};
          parse_ph   = PH_LEN_LO;
        end else begin
          bytes_left = {8'h00, b[6:0]};
          len_done   = 1'b1;
        end
      end
      PH_LEN_LO: begin
        bytes_left = bytes_left | {7'd0, b};
        len_done   = 1'b1;
      end
      PH_DATA: begin
        res[n] = make_result(KIND_DATA, b, '0, 1'b0);
        n++;
        bytes_left = bytes_left - 1'b1;
        if (bytes_left == '0) begin
          if (delay_req) begin
            parse_ph = PH_DELAY;
          end else begin
            res[n] = make_result(KIND_PAUSE, '0, '0, wb);
            n++;
            parse_ph = PH_CMD;
          end
        end
      end
      PH_DELAY: begin
        res[n] = make_result(KIND_PAUSE, '0,
                             (b == DELAY_LONG_CODE) ? DELAY_LONG_MS : MS_W'(b), wb);
        n++;
        delay_req = 1'b0;
        parse_ph  = PH_CMD;
      end
      default: begin
        res[n] = make_result(KIND_CMD, b, '0, 1'b0);
        n++;
        bytes_left = '0;
        delay_req  = 1'b0;
        parse_ph   = PH_LEN;
      end
    endcase
    // length known: data follows, or the entry is already over
    if (len_done) begin
      if (bytes_left != '0) begin
        parse_ph = PH_DATA;
      end else if (delay_req) begin
        parse_ph = PH_DELAY;
      end else begin
        res[n] = make_result(KIND_PAUSE, '0, '0, wb);
        n++;
        parse_ph = PH_CMD;
      end
    end
    if (last) begin
      parse_ph   = PH_CMD;
      bytes_left = '0;
      delay_req  = 1'b0;
    end
    if (n > 0) res[n-1].run_last = 1'b1;
    for (int i = 0; i < n; i++) awaited_q.push_back(res[i]);
  endtask

  always @(posedge clk) begin : watch
    seq_result_t want;
    if (!rst_n) begin
      parse_ph   = PH_CMD;
      bytes_left = '0;
      delay_req  = 1'b0;
      long_len   = 1'b0;
      errors     = 0;
      checked    = 0;
      awaited_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (awaited_q.size() == 0) begin
          $error("result with nothing awaited: kind %0d tdata %h", out_tuser, out_tdata);
          errors++;
        end else begin
          want = awaited_q.pop_front();
          checked++;
          if (out_tuser !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_tuser);
            errors++;
          end
          if (out_tdata[7:0] !== want.byte_out) begin
            $error("byte_out: expected %0d, got %0d", want.byte_out, out_tdata[7:0]);
            errors++;
          end
          if (out_tdata[16:8] !== want.pause_ms) begin
            $error("pause_ms: expected %0d, got %0d", want.pause_ms, out_tdata[16:8]);
            errors++;
          end
          if (out_tdata[17] !== want.wait_after) begin
            $error("wait_after: expected %0d, got %0d", want.wait_after, out_tdata[17]);
            errors++;
          end
          if (out_tlast !== want.run_last) begin
            $error("run_last: expected %0d, got %0d", want.run_last, out_tlast);
            errors++;
          end
        end
      end
      if (cfg_valid && cfg_ready) long_len = cfg_data;
      if (in_tvalid && in_tready) play_byte(in_tdata[7:0], in_tlast, in_tdata[8]);
    end
    pending = awaited_q.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
// testbench top for the display command sequence player: stimulus, handshake idling and verdict
`timescale 1ns / 100ps
module tb;
  import dcsp_pkg::*;

  localparam int RANDOM_ITEMS = 2000;   // spread over the four idling phases
  localparam int HOLD_CYCLES  = 400;    // long output hold-off, fills the entry queue
  localparam int DRAIN_CYCLES = 10;     // settling time once no result is awaited
  localparam int CYCLE_LIMIT  = 400000; // far above the slowest legal run

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // seq_byte[7:0], wait_busy[8], zero pad
  logic        in_tlast;   // seq_last
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // byte_out[7:0], pause_ms[16:8], wait_after[17], zero pad
  logic [1:0]  out_tuser;  // kind
  logic        out_tlast;  // run_last
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  int errors;
  int pending;
  int checked;

  // stimulus bookkeeping
  logic [SEQ_W-1:0] seq_q[$];  // bytes of the sequence being built
  logic             len_mode;  // current two_byte_length setting
  int               sent = 0;  // accepted input items
  int               idle_pct = 0;
  int               stall_pct = 0;
  int               hold_req = 0; // bumped to ask the receiver for a long hold-off
  int               cycles = 0;

  always #2 clk = ~clk;

  display_command_sequence_player_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  dcsp_seq_checker u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked)
  );

  // watchdog: a stuck handshake or a lost result ends up here
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random back-pressure, plus one long hold-off counted here
  initial begin : receiver
    int hold_cnt;
    int hold_seen;
    hold_cnt   = 0;
    hold_seen  = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_cnt  = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        out_tready <= 1'b0;
        hold_cnt--;
      end else begin
        out_tready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // one sequence byte, with random gaps in front; called and left at a falling edge
  task automatic send_byte(input logic [SEQ_W-1:0] b, input logic last, input logic wb);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, wb, b};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sent++;
    @(negedge clk);
  endtask

  // send the first cut bytes of the built sequence, the last of them marked
  task automatic send_seq(input int cut);
    for (int i = 0; i < cut; i++) send_byte(seq_q[i], i == cut - 1, 1'($urandom_range(1)));
    seq_q.delete();
  endtask

  // append one entry, well-formed unless keep caps the data bytes actually built
  task automatic add_entry(input int max_len, input int keep);
    int   len;
    logic dly;
    len = ($urandom_range(15) == 0) ? $urandom_range(max_len) : $urandom_range(6);
    dly = 1'($urandom_range(1));
    seq_q.push_back(8'($urandom_range(255)));
    if (len_mode) begin
      seq_q.push_back({dly, 7'(len >> 8)});
      seq_q.push_back(8'(len));
    end else begin
      seq_q.push_back({dly, 7'(len)});
    end
    for (int i = 0; i < len && i < keep; i++) seq_q.push_back(8'($urandom_range(255)));
    if (dly) seq_q.push_back(($urandom_range(4) == 0) ? DELAY_LONG_CODE : 8'($urandom_range(255)));
  endtask

  // mostly whole sequences, some cut short mid-entry, some plain noise
  task automatic random_seq();
    int pick;
    pick = $urandom_range(99);
    if (pick < 80) begin
      repeat ($urandom_range(1, 4)) add_entry(len_mode ? 300 : 127, 1 << 15);
      send_seq(seq_q.size());
    end else if (pick < 90) begin
      add_entry(len_mode ? 32767 : 127, 8);
      send_seq($urandom_range(1, (seq_q.size() < 8) ? seq_q.size() : 8));
    end else begin
      repeat ($urandom_range(1, 6)) seq_q.push_back(8'($urandom_range(255)));
      send_seq(seq_q.size());
    end
  endtask

  // wait for every awaited result, then let an empty length byte settle too
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_cfg(input logic v);
    len_mode   = v;
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = 1'b0;
    len_mode  = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed, one-byte lengths
    write_cfg(1'b0);
    // empty entry, two data bytes ending in a pause, delay 255 as 500 ms,
    // empty entry with delay 0, empty entry with delay 254
    seq_q = '{8'h00, 8'h00, 8'hFF, 8'h02, 8'h00, 8'hFF,
              8'h5A, 8'h81, 8'hA5, DELAY_LONG_CODE,
              8'h11, 8'h80, 8'h00, 8'h22, 8'h80, 8'hFE};
    send_seq(seq_q.size());
    // cut short in the middle of the data, then last on an entry end
    seq_q = '{8'h33, 8'h03, 8'h01};
    send_seq(3);
    seq_q = '{8'h44, 8'h01, 8'h77};
    send_seq(3);
    settle();

    // directed, two-byte lengths
    write_cfg(1'b1);
    // longest length with delay, cut short after two data bytes
    seq_q = '{8'hC3, 8'hFF, 8'hFF, 8'h12, 8'h34};
    send_seq(5);
    // empty entry, then one data byte with a long delay
    seq_q = '{8'h01, 8'h00, 8'h00, 8'h02, 8'h80, 8'h01, 8'h9C, DELAY_LONG_CODE};
    send_seq(8);
    // length above 255 must not be truncated, cut short
    seq_q = '{8'h03, 8'h01, 8'h00, 8'hAA, 8'h55};
    send_seq(5);

    // random phases: no idling with a long output hold-off, sender idle,
    // receiver stalling, both idle now and then; length mode alternates
    for (int p = 0; p < 4; p++) begin
      int target;
      settle();
      write_cfg(1'(p % 2));
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  hold_req++; end
        1: begin idle_pct = 79; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 79; end
        default: begin idle_pct = 10; stall_pct = 10; end
      endcase
      target = sent + RANDOM_ITEMS / 4;
      while (sent < target) random_seq();
    end
    settle();

    $display("covered %0d sequence items: both length modes, cut and noisy sequences,", sent);
    $display("four idling phases and a long output hold-off; %0d results compared", checked);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
